### rtl/wdlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdlt_pkg: shared definitions of the wait-die lock table
// Request and outcome codes, table sizes and the layout of one table entry.
// ----------------------------------------------------------------------------
package wdlt_pkg;

  localparam int LOCK_ENTRIES = 1024;
  localparam int READER_BITS  = 8;
  localparam int ADDR_W       = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;

  localparam int REQ_W   = 2;
  localparam int INDEX_W = 10;
  localparam int TS_W    = 64;
  localparam int OUT_W   = 3;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ACQ_SH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACQ_EX = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REL_SH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REL_EX = 2'd3;

  // Outcome codes.
  localparam logic [OUT_W-1:0] OUT_GRANTED   = 3'd0;
  localparam logic [OUT_W-1:0] OUT_WAIT      = 3'd1;
  localparam logic [OUT_W-1:0] OUT_ABORT     = 3'd2;
  localparam logic [OUT_W-1:0] OUT_RELEASED  = 3'd3;
  localparam logic [OUT_W-1:0] OUT_REL_ERROR = 3'd4;

  typedef struct packed {
    logic [TS_W-1:0]        holder_ts;
    logic                   writer_held;
    logic [READER_BITS-1:0] reader_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/wdlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdlt_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module wdlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/wait_die_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_die_lock_table: reader/writer lock table under the wait-die rule
// Grants, reports waits for or aborts lock requests, handles releases and tracks the oldest holder.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (kind in in_tuser, lock index and
//   transaction timestamp in in_tdata). Each request yields exactly one
//   result on the out_ channel: outcome, echoed lock index and the entry's
//   oldest holder timestamp after the request.
//   When a request is accepted, its edge registers the request and the
//   synchronous table read; the update then writes back and loads the result
//   register, raising out_tvalid, once that register is free. One request per
//   cycle is sustained while the receiver keeps out_tready high; the single
//   table read-modify-write sets that figure, and back-to-back requests to
//   the same lock are forwarded from the previous write.
//   After reset a clearing pass writes every table entry to zero, one entry
//   per cycle, and in_tready stays low until the pass is done.
//   When the receiver stalls, the result register holds, the request in the
//   update stage waits behind it, and in_tready drops until space frees up.
// ----------------------------------------------------------------------------
module wait_die_lock_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [79:0]          in_tdata,  // lock_index[9:0], txn_ts[73:10], zero fill
  input  logic [wdlt_pkg::REQ_W-1:0] in_tuser, // req_type[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata  // outcome[2:0], lock_echo[12:3],
                                          // oldest_ts[76:13], zero fill
);

  import wdlt_pkg::*;

  localparam logic [16:0] ENTRIES_C = 17'(LOCK_ENTRIES);

  // Clearing pass.
  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Update stage.
  logic               s1_valid_r, s1_valid_nxt;
  logic [REQ_W-1:0]   s1_req_r;
  logic [INDEX_W-1:0] s1_idx_r;
  logic [TS_W-1:0]    s1_ts_r;
  logic               s1_adv;
  logic               s1_in_range;
  logic [ADDR_W-1:0]  s1_addr;

  // Forwarding of the most recent table write.
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [ADDR_W-1:0] fwd_addr_r;
  entry_t            fwd_data_r;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_code_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic [TS_W-1:0]    out_ts_r;

  // Table port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_acc;

  entry_t           cur;
  entry_t           entry_nxt;
  logic [OUT_W-1:0] code_nxt;
  logic [TS_W-1:0]  oldest_nxt;
  logic             conflict;
  logic             ts_older;
  logic [READER_BITS-1:0] rd_dec;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready   = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc      = in_tvalid && in_tready;
  assign s1_in_range = {7'd0, s1_idx_r} < ENTRIES_C;
  assign s1_addr     = ADDR_W'(s1_idx_r);

  assign ram_re    = in_acc;
  assign ram_raddr = ADDR_W'(in_tdata[INDEX_W-1:0]);

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_in_range;
      ram_waddr = s1_addr;
      ram_wdata = entry_nxt;
    end
  end

  wdlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOCK_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The read for this request may have been issued in the cycle the previous request
  // wrote back, so a matching address takes the written value instead.
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      cur = fwd_data_r;
    end else begin
      cur = entry_t'(ram_rdata);
    end
  end

  always_comb begin
    entry_nxt = cur;
    code_nxt  = OUT_ABORT;
    ts_older  = s1_ts_r < cur.holder_ts;
    rd_dec    = cur.reader_count - READER_BITS'(1);
    if (s1_req_r == REQ_ACQ_EX) begin
      conflict = cur.writer_held || (cur.reader_count != '0);
    end else begin
      conflict = cur.writer_held;
    end
    case (s1_req_r)
      REQ_ACQ_SH, REQ_ACQ_EX: begin
        if (conflict) begin
          code_nxt = ts_older ? OUT_WAIT : OUT_ABORT;
        end else if ((s1_req_r == REQ_ACQ_SH) && (&cur.reader_count)) begin
          code_nxt = OUT_WAIT;
        end else begin
          code_nxt = OUT_GRANTED;
          if (s1_req_r == REQ_ACQ_SH) begin
            entry_nxt.reader_count = cur.reader_count + READER_BITS'(1);
          end else begin
            entry_nxt.writer_held = 1'b1;
          end
          if ((cur.holder_ts == '0) || ts_older) begin
            entry_nxt.holder_ts = s1_ts_r;
          end
        end
      end
      REQ_REL_SH: begin
        if (cur.reader_count == '0) begin
          code_nxt = OUT_REL_ERROR;
        end else begin
          code_nxt               = OUT_RELEASED;
          entry_nxt.reader_count = rd_dec;
          if ((rd_dec == '0) && !cur.writer_held) begin
            entry_nxt.holder_ts = '0;
          end
        end
      end
      REQ_REL_EX: begin
        if (!cur.writer_held) begin
          code_nxt = OUT_REL_ERROR;
        end else begin
          code_nxt              = OUT_RELEASED;
          entry_nxt.writer_held = 1'b0;
          entry_nxt.holder_ts   = '0;
        end
      end
      default: begin
        code_nxt = OUT_ABORT;
      end
    endcase
    oldest_nxt = entry_nxt.holder_ts;
    if (!s1_in_range) begin
      code_nxt   = s1_req_r[1] ? OUT_REL_ERROR : OUT_ABORT;
      oldest_nxt = '0;
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(LOCK_ENTRIES - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
    fwd_valid_nxt = clearing_r ? 1'b0 : (fwd_valid_r || (s1_adv && s1_in_range));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_tuser;
      s1_idx_r <= in_tdata[INDEX_W-1:0];
      s1_ts_r  <= in_tdata[INDEX_W+TS_W-1:INDEX_W];
    end
    if (s1_adv && s1_in_range) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= entry_nxt;
    end
    if (s1_adv) begin
      out_code_r <= code_nxt;
      out_idx_r  <= s1_idx_r;
      out_ts_r   <= oldest_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_ts_r, out_idx_r, out_code_r};

endmodule
